@@ rtl/time_rotating_path_transform_assert.svh @@
// Assertion macros used by the checker file of this block.
`ifndef TIME_ROTATING_PATH_TRANSFORM_ASSERT_SVH
`define TIME_ROTATING_PATH_TRANSFORM_ASSERT_SVH

// Same-cycle implication, sampled on clk and off while rst is high.
`define TRPT_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, sampled on clk and off while rst is high.
`define TRPT_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

@@ rtl/trpt_pkg.sv @@
`default_nettype none
package trpt_pkg;

  localparam int FRAC_BITS    = 8;
  localparam int CORDIC_STEPS = 16;
  localparam int GUARD_BITS   = 8;

  localparam int COORD_W = 20;
  localparam int SHIFT_W = 11;
  localparam int TIME_W  = 48;
  localparam int RATE_W  = 32;
  localparam int STEP_W  = 8;
  localparam int DATA_W  = 64;
  localparam int ADDR_W  = 6;
  localparam int REG_IDX_W = ADDR_W - 3;

  localparam int STEP_RESET = 4;

  localparam int SUM_W = ((COORD_W > SHIFT_W + FRAC_BITS) ? COORD_W :
                          SHIFT_W + FRAC_BITS) + 1;
  localparam int XY_W  = SUM_W + GUARD_BITS + 3;
  localparam int Z_W   = RATE_W;
  localparam int IDX_W = $clog2(CORDIC_STEPS);

  localparam int GAIN_W = 31;
  localparam logic signed [GAIN_W-1:0] GAIN_Q30 = 31'sd652032874;
  localparam int SCALE  = 30 + GUARD_BITS;
  localparam int PROD_W = XY_W + GAIN_W;
  localparam int RND_W  = PROD_W - SCALE;
  localparam logic [PROD_W-1:0] ROUND_HALF = PROD_W'(1) << (SCALE - 1);

  localparam logic [31:0] ATAN_TURNS [0:23] = '{
    32'd536870912, 32'd316933406, 32'd167458907, 32'd85004756,
    32'd42667331,  32'd21354465,  32'd10679838,  32'd5340245,
    32'd2670163,   32'd1335087,   32'd667544,    32'd333772,
    32'd166886,    32'd83443,     32'd41722,     32'd20861,
    32'd10430,     32'd5215,      32'd2608,      32'd1304,
    32'd652,       32'd326,       32'd163,       32'd81
  };

  typedef enum logic [REG_IDX_W-1:0] {
    REG_ANGULAR_RATE  = 3'd0,
    REG_TIME_STEP_MS  = 3'd1,
    REG_START_TIME_MS = 3'd2,
    REG_SHIFT_X       = 3'd3,
    REG_SHIFT_Y       = 3'd4
  } reg_idx_t;

  typedef struct packed {
    logic [RATE_W-1:0]  angular_rate;
    logic [STEP_W-1:0]  time_step_ms;
    logic [TIME_W-1:0]  start_time_ms;
    logic [SHIFT_W-1:0] shift_x;
    logic [SHIFT_W-1:0] shift_y;
  } cfg_t;

  typedef struct packed {
    logic signed [XY_W-1:0] x;
    logic signed [XY_W-1:0] y;
    logic signed [Z_W-1:0]  z;
  } vec_t;

  function automatic logic signed [COORD_W-1:0] round_sat(
    input logic signed [PROD_W-1:0] p
  );
    logic [PROD_W-1:0]  sum;
    logic [RND_W-1:0]   r;
    logic [COORD_W-1:0] res;
    sum = p + ROUND_HALF;
    r   = sum[PROD_W-1:SCALE];
    if (r[RND_W-1:COORD_W-1] != {(RND_W-COORD_W+1){r[RND_W-1]}}) begin
      res = r[RND_W-1] ? {1'b1, {(COORD_W-1){1'b0}}} : {1'b0, {(COORD_W-1){1'b1}}};
    end else begin
      res = r[COORD_W-1:0];
    end
    return res;
  endfunction

endpackage
`default_nettype wire

@@ rtl/trpt_cell.sv @@
`default_nettype none
module trpt_cell (
  input  logic                       clk,
  input  logic                       rst,
  input  logic [trpt_pkg::IDX_W-1:0] step_idx,
  input  logic [trpt_pkg::Z_W-1:0]   angle,
  input  logic                       up_valid,
  input  trpt_pkg::vec_t             up_vec,
  output logic                       valid,
  output trpt_pkg::vec_t             vec
);
  import trpt_pkg::*;

  logic signed [XY_W-1:0] dx;
  logic signed [XY_W-1:0] dy;
  vec_t                   vec_next;

  always_comb begin
    dx = $signed(up_vec.y) >>> step_idx;
    dy = $signed(up_vec.x) >>> step_idx;
    if (!up_vec.z[Z_W-1]) begin
      vec_next.x = up_vec.x - dx;
      vec_next.y = up_vec.y + dy;
      vec_next.z = up_vec.z - angle;
    end else begin
      vec_next.x = up_vec.x + dx;
      vec_next.y = up_vec.y - dy;
      vec_next.z = up_vec.z + angle;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else begin
      valid <= up_valid;
    end
  end

  always_ff @(posedge clk) begin
    vec <= vec_next;
  end

endmodule
`default_nettype wire

@@ rtl/trpt_regs.sv @@
`default_nettype none
module trpt_regs (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [trpt_pkg::ADDR_W-1:0] paddr,
  input  logic [trpt_pkg::DATA_W-1:0] pwdata,
  output logic [trpt_pkg::DATA_W-1:0] prdata,
  output logic                        pready,
  output trpt_pkg::cfg_t              cfg
);
  import trpt_pkg::*;

  logic [RATE_W-1:0]    angular_rate;
  logic [STEP_W-1:0]    time_step_ms;
  logic [TIME_W-1:0]    start_time_ms;
  logic [SHIFT_W-1:0]   shift_x;
  logic [SHIFT_W-1:0]   shift_y;
  logic [REG_IDX_W-1:0] idx;
  logic                 wr;

  assign pready = 1'b1;
  assign idx    = paddr[ADDR_W-1:3];
  assign wr     = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      angular_rate  <= '0;
      time_step_ms  <= STEP_W'(STEP_RESET);
      start_time_ms <= '0;
      shift_x       <= '0;
      shift_y       <= '0;
    end else if (wr) begin
      unique case (reg_idx_t'(idx))
        REG_ANGULAR_RATE:  angular_rate  <= pwdata[RATE_W-1:0];
        REG_TIME_STEP_MS:  time_step_ms  <= pwdata[STEP_W-1:0];
        REG_START_TIME_MS: start_time_ms <= pwdata[TIME_W-1:0];
        REG_SHIFT_X:       shift_x       <= pwdata[SHIFT_W-1:0];
        REG_SHIFT_Y:       shift_y       <= pwdata[SHIFT_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (reg_idx_t'(idx))
      REG_ANGULAR_RATE:  prdata = DATA_W'(angular_rate);
      REG_TIME_STEP_MS:  prdata = DATA_W'(time_step_ms);
      REG_START_TIME_MS: prdata = DATA_W'(start_time_ms);
      REG_SHIFT_X:       prdata = DATA_W'(shift_x);
      REG_SHIFT_Y:       prdata = DATA_W'(shift_y);
      default:           prdata = '0;
    endcase
  end

  assign cfg.angular_rate  = angular_rate;
  assign cfg.time_step_ms  = time_step_ms;
  assign cfg.start_time_ms = start_time_ms;
  assign cfg.shift_x       = shift_x;
  assign cfg.shift_y       = shift_y;

endmodule
`default_nettype wire

@@ rtl/time_rotating_path_transform.sv @@
// Rotates path points by an angle that grows with each point's time stamp.
// Input channel: point_valid / point_stall carry point_x, point_y, path_start.
// A word with path_start set reloads the point time from start_time_ms; each
// word then advances the time by time_step_ms.
// Output channel: result_valid / result_stall carry rotated_x, rotated_y and
// stamp_ms, one word for each input word, in order.
// Registers are written over the APB port at byte address 8*i; the user must
// write them only while idle, as the block does not enforce it. A word passes
// the load register, the phase multiply, the row of CORDIC cells, the gain
// multiply and the rounding stage on its way to result_valid. One point is in
// the row at a time: point_stall stays high from acceptance until the result
// reaches the output register, and only then is a new word taken.
// A stalled result waits in the output register while the next point enters.
// Reset clears the point time to zero, drops any word in flight and returns
// the registers to their defaults (time_step_ms is 4, the others zero).
`default_nettype none
module time_rotating_path_transform (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         psel,
  input  logic                         penable,
  input  logic                         pwrite,
  input  logic [trpt_pkg::ADDR_W-1:0]  paddr,
  input  logic [trpt_pkg::DATA_W-1:0]  pwdata,
  output logic [trpt_pkg::DATA_W-1:0]  prdata,
  output logic                         pready,
  input  logic                         point_valid,
  output logic                         point_stall,
  input  logic signed [trpt_pkg::COORD_W-1:0] point_x,
  input  logic signed [trpt_pkg::COORD_W-1:0] point_y,
  input  logic                         path_start,
  output logic                         result_valid,
  input  logic                         result_stall,
  output logic signed [trpt_pkg::COORD_W-1:0] rotated_x,
  output logic signed [trpt_pkg::COORD_W-1:0] rotated_y,
  output logic [trpt_pkg::TIME_W-1:0]  stamp_ms
);
  import trpt_pkg::*;

  typedef enum logic [1:0] {
    QTR_0   = 2'd0,
    QTR_90  = 2'd1,
    QTR_180 = 2'd2,
    QTR_270 = 2'd3
  } quarter_t;

  localparam logic [Z_W-1:0] QTR_HALF = Z_W'(1) << (Z_W - 3);

  cfg_t                   cfg;
  logic                   accept;
  logic                   busy;
  logic [TIME_W-1:0]      point_time;
  logic [TIME_W-1:0]      t_sel;
  logic [TIME_W-1:0]      stamp;
  logic [SUM_W-1:0]       sum_x;
  logic [SUM_W-1:0]       sum_y;
  logic signed [XY_W-1:0] pt_x;
  logic signed [XY_W-1:0] pt_y;
  logic                   v_load;
  logic                   v_phase;
  logic [RATE_W-1:0]      phase;
  logic [Z_W-1:0]         phase_rnd;
  logic [1:0]             q;
  vec_t                   start_vec;
  vec_t                   chain_vec [0:CORDIC_STEPS];
  logic [CORDIC_STEPS:0]  chain_valid;
  logic                   pv;
  logic signed [PROD_W-1:0] gx;
  logic signed [PROD_W-1:0] gy;
  logic                   move;

  trpt_regs u_regs (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  assign point_stall = busy;
  assign accept      = point_valid && !busy;
  assign t_sel       = path_start ? cfg.start_time_ms : point_time;

  assign sum_x = {{(SUM_W-COORD_W){point_x[COORD_W-1]}}, point_x}
               + {{(SUM_W-SHIFT_W-FRAC_BITS){cfg.shift_x[SHIFT_W-1]}}, cfg.shift_x,
                  {FRAC_BITS{1'b0}}};
  assign sum_y = {{(SUM_W-COORD_W){point_y[COORD_W-1]}}, point_y}
               + {{(SUM_W-SHIFT_W-FRAC_BITS){cfg.shift_y[SHIFT_W-1]}}, cfg.shift_y,
                  {FRAC_BITS{1'b0}}};

  always_ff @(posedge clk) begin
    if (rst) begin
      point_time <= '0;
      v_load     <= 1'b0;
      v_phase    <= 1'b0;
    end else begin
      if (accept) begin
        point_time <= t_sel + TIME_W'(cfg.time_step_ms);
      end
      v_load  <= accept;
      v_phase <= v_load;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      stamp <= t_sel;
      pt_x  <= {{(XY_W-SUM_W-GUARD_BITS){sum_x[SUM_W-1]}}, sum_x, {GUARD_BITS{1'b0}}};
      pt_y  <= {{(XY_W-SUM_W-GUARD_BITS){sum_y[SUM_W-1]}}, sum_y, {GUARD_BITS{1'b0}}};
    end
    if (v_load) begin
      phase <= cfg.angular_rate * stamp[RATE_W-1:0];
    end
  end

  assign phase_rnd = phase + QTR_HALF;
  assign q         = phase_rnd[Z_W-1:Z_W-2];

  always_comb begin
    start_vec.z = phase - {q, {(Z_W-2){1'b0}}};
    unique case (quarter_t'(q))
      QTR_0: begin
        start_vec.x = pt_x;
        start_vec.y = pt_y;
      end
      QTR_90: begin
        start_vec.x = -pt_y;
        start_vec.y = pt_x;
      end
      QTR_180: begin
        start_vec.x = -pt_x;
        start_vec.y = -pt_y;
      end
      QTR_270: begin
        start_vec.x = pt_y;
        start_vec.y = -pt_x;
      end
      default: begin
        start_vec.x = pt_x;
        start_vec.y = pt_y;
      end
    endcase
  end

  assign chain_vec[0]   = start_vec;
  assign chain_valid[0] = v_phase;

  for (genvar g = 0; g < CORDIC_STEPS; g++) begin : g_cell
    trpt_cell u_cell (
      .clk      (clk),
      .rst      (rst),
      .step_idx (IDX_W'(g)),
      .angle    (Z_W'(ATAN_TURNS[g])),
      .up_valid (chain_valid[g]),
      .up_vec   (chain_vec[g]),
      .valid    (chain_valid[g+1]),
      .vec      (chain_vec[g+1])
    );
  end

  assign move = pv && (!result_valid || !result_stall);

  always_ff @(posedge clk) begin
    if (chain_valid[CORDIC_STEPS]) begin
      gx <= $signed(chain_vec[CORDIC_STEPS].x) * GAIN_Q30;
      gy <= $signed(chain_vec[CORDIC_STEPS].y) * GAIN_Q30;
    end
    if (move) begin
      rotated_x <= round_sat(gx);
      rotated_y <= round_sat(gy);
      stamp_ms  <= stamp;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy         <= 1'b0;
      pv           <= 1'b0;
      result_valid <= 1'b0;
    end else begin
      if (accept) begin
        busy <= 1'b1;
      end else if (move) begin
        busy <= 1'b0;
      end
      if (chain_valid[CORDIC_STEPS]) begin
        pv <= 1'b1;
      end else if (move) begin
        pv <= 1'b0;
      end
      if (move) begin
        result_valid <= 1'b1;
      end else if (!result_stall) begin
        result_valid <= 1'b0;
      end
    end
  end

endmodule
`default_nettype wire

@@ rtl/trpt_checker.sv @@
`default_nettype none
`include "time_rotating_path_transform_assert.svh"
module trpt_checker (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 point_valid,
  input  logic                                 point_stall,
  input  logic                                 result_valid,
  input  logic                                 result_stall,
  input  logic signed [trpt_pkg::COORD_W-1:0]  rotated_x,
  input  logic signed [trpt_pkg::COORD_W-1:0]  rotated_y,
  input  logic [trpt_pkg::TIME_W-1:0]          stamp_ms
);

  `TRPT_ASSERT_NEXT(a_one_in_flight, point_valid && !point_stall, point_stall, "second word taken while one is in flight")
  `TRPT_ASSERT_NEXT(a_result_hold, result_valid && result_stall, result_valid && $stable(rotated_x) && $stable(rotated_y) && $stable(stamp_ms), "stalled result changed")
  `TRPT_ASSERT_NEXT(a_result_gap, result_valid && !result_stall, !result_valid, "result repeated right after it was taken")
  `TRPT_ASSERT_NOW(a_reset_idle, $past(rst), !result_valid && !point_stall, "block not idle after reset")

endmodule

bind time_rotating_path_transform trpt_checker u_trpt_checker (
  .clk          (clk),
  .rst          (rst),
  .point_valid  (point_valid),
  .point_stall  (point_stall),
  .result_valid (result_valid),
  .result_stall (result_stall),
  .rotated_x    (rotated_x),
  .rotated_y    (rotated_y),
  .stamp_ms     (stamp_ms)
);
`default_nettype wire

@@ tb/time_rotating_path_transform_checker.sv @@
`timescale 1ns / 1ps
module time_rotating_path_transform_checker (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                psel,
  input  logic                                penable,
  input  logic                                pwrite,
  input  logic                                pready,
  input  logic [trpt_pkg::ADDR_W-1:0]         paddr,
  input  logic [trpt_pkg::DATA_W-1:0]         pwdata,
  input  logic [trpt_pkg::DATA_W-1:0]         prdata,
  input  logic                                point_valid,
  input  logic                                point_stall,
  input  logic signed [trpt_pkg::COORD_W-1:0] point_x,
  input  logic signed [trpt_pkg::COORD_W-1:0] point_y,
  input  logic                                path_start,
  input  logic                                result_valid,
  input  logic                                result_stall,
  input  logic signed [trpt_pkg::COORD_W-1:0] rotated_x,
  input  logic signed [trpt_pkg::COORD_W-1:0] rotated_y,
  input  logic [trpt_pkg::TIME_W-1:0]         stamp_ms,
  output int                                  failures,
  output int                                  outstanding
);
  import trpt_pkg::*;

  localparam longint COORD_HI = (longint'(1) <<< (COORD_W - 1)) - 1;
  localparam longint COORD_LO = -(longint'(1) <<< (COORD_W - 1));
  localparam longint GAIN = 652032874;
  localparam longint ROUNDING = longint'(1) <<< (30 + GUARD_BITS - 1);
  localparam longint ARC_TURN [24] = '{
    536870912, 316933406, 167458907, 85004756, 42667331, 21354465,
    10679838, 5340245, 2670163, 1335087, 667544, 333772,
    166886, 83443, 41722, 20861, 10430, 5215,
    2608, 1304, 652, 326, 163, 81
  };

  typedef struct {
    logic signed [COORD_W-1:0] x;
    logic signed [COORD_W-1:0] y;
    logic [TIME_W-1:0]         stamp;
  } rotated_point_t;

  logic [RATE_W-1:0]         rate_reg;
  logic [STEP_W-1:0]         step_reg;
  logic [TIME_W-1:0]         start_reg;
  logic signed [SHIFT_W-1:0] shift_x_reg;
  logic signed [SHIFT_W-1:0] shift_y_reg;
  logic [TIME_W-1:0]         point_time;
  rotated_point_t            expected_points [$];

  function automatic logic signed [COORD_W-1:0] clamp_coord(input longint v);
    if (v > COORD_HI) begin
      v = COORD_HI;
    end
    if (v < COORD_LO) begin
      v = COORD_LO;
    end
    return v[COORD_W-1:0];
  endfunction

  function automatic rotated_point_t rotate_point(
    input logic signed [COORD_W-1:0] px,
    input logic signed [COORD_W-1:0] py,
    input logic [TIME_W-1:0]         t
  );
    rotated_point_t res;
    logic [63:0]    prod;
    logic [31:0]    phase;
    logic [31:0]    rounded;
    logic [31:0]    resid;
    logic [1:0]     quarter;
    longint         x, y, z, tmp, dx, dy;
    prod    = {32'd0, rate_reg} * {32'd0, t[31:0]};
    phase   = prod[31:0];
    rounded = phase + 32'h2000_0000;
    quarter = rounded[31:30];
    resid   = phase - {quarter, 30'd0};
    z = longint'($signed(resid));
    x = (longint'(px) + (longint'(shift_x_reg) <<< FRAC_BITS)) <<< GUARD_BITS;
    y = (longint'(py) + (longint'(shift_y_reg) <<< FRAC_BITS)) <<< GUARD_BITS;
    case (quarter)
      2'd1: begin
        tmp = x;
        x = -y;
        y = tmp;
      end
      2'd2: begin
        x = -x;
        y = -y;
      end
      2'd3: begin
        tmp = x;
        x = y;
        y = -tmp;
      end
      default: ;
    endcase
    for (int i = 0; i < CORDIC_STEPS && i < 24; i++) begin
      dx = y >>> i;
      dy = x >>> i;
      if (z >= 0) begin
        x = x - dx;
        y = y + dy;
        z = z - ARC_TURN[i];
      end else begin
        x = x + dx;
        y = y - dy;
        z = z + ARC_TURN[i];
      end
    end
    res.x = clamp_coord((x * GAIN + ROUNDING) >>> (30 + GUARD_BITS));
    res.y = clamp_coord((y * GAIN + ROUNDING) >>> (30 + GUARD_BITS));
    res.stamp = t;
    return res;
  endfunction

  always @(posedge clk) begin : watch
    rotated_point_t    want;
    logic [DATA_W-1:0] read_want;
    if (rst) begin
      rate_reg    = '0;
      step_reg    = STEP_W'(STEP_RESET);
      start_reg   = '0;
      shift_x_reg = '0;
      shift_y_reg = '0;
      point_time  = '0;
      failures    = 0;
      expected_points.delete();
    end else begin
      if (psel && penable && !pwrite && pready) begin
        case (reg_idx_t'(paddr[ADDR_W-1:3]))
          REG_ANGULAR_RATE:  read_want = DATA_W'(rate_reg);
          REG_TIME_STEP_MS:  read_want = DATA_W'(step_reg);
          REG_START_TIME_MS: read_want = DATA_W'(start_reg);
          REG_SHIFT_X:       read_want = DATA_W'($unsigned(shift_x_reg));
          REG_SHIFT_Y:       read_want = DATA_W'($unsigned(shift_y_reg));
          default:           read_want = '0;
        endcase
        if (prdata !== read_want) begin
          $display("%0t: prdata at %0d expected %0h, actual %0h",
                   $time, paddr, read_want, prdata);
          failures++;
        end
      end
      if (psel && penable && pwrite && pready) begin
        case (reg_idx_t'(paddr[ADDR_W-1:3]))
          REG_ANGULAR_RATE:  rate_reg    = pwdata[RATE_W-1:0];
          REG_TIME_STEP_MS:  step_reg    = pwdata[STEP_W-1:0];
          REG_START_TIME_MS: start_reg   = pwdata[TIME_W-1:0];
          REG_SHIFT_X:       shift_x_reg = pwdata[SHIFT_W-1:0];
          REG_SHIFT_Y:       shift_y_reg = pwdata[SHIFT_W-1:0];
          default: ;
        endcase
      end
      if (result_valid && !result_stall) begin
        if (expected_points.size() == 0) begin
          $display("%0t: unexpected result word x=%0d y=%0d stamp=%0d",
                   $time, rotated_x, rotated_y, stamp_ms);
          failures++;
        end else begin
          want = expected_points.pop_front();
          if (rotated_x !== want.x) begin
            $display("%0t: rotated_x expected %0d, actual %0d", $time, want.x, rotated_x);
            failures++;
          end
          if (rotated_y !== want.y) begin
            $display("%0t: rotated_y expected %0d, actual %0d", $time, want.y, rotated_y);
            failures++;
          end
          if (stamp_ms !== want.stamp) begin
            $display("%0t: stamp_ms expected %0d, actual %0d", $time, want.stamp, stamp_ms);
            failures++;
          end
        end
      end
      if (point_valid && !point_stall) begin
        if (path_start) begin
          point_time = start_reg;
        end
        expected_points.insert(expected_points.size(),
                               rotate_point(point_x, point_y, point_time));
        point_time = point_time + TIME_W'(step_reg);
      end
    end
    outstanding = expected_points.size();
  end

endmodule

@@ tb/tb_time_rotating_path_transform.sv @@
`timescale 1ns / 1ps
module tb_time_rotating_path_transform;
  import trpt_pkg::*;

  localparam int RANDOM_ITEMS = 1350;
  localparam logic signed [COORD_W-1:0] COORD_MAX = {1'b0, {(COORD_W-1){1'b1}}};
  localparam logic signed [COORD_W-1:0] COORD_MIN = {1'b1, {(COORD_W-1){1'b0}}};
  localparam logic signed [SHIFT_W-1:0] SHIFT_MAX = {1'b0, {(SHIFT_W-1){1'b1}}};
  localparam logic signed [SHIFT_W-1:0] SHIFT_MIN = {1'b1, {(SHIFT_W-1){1'b0}}};

  logic                      clk = 1'b0;
  logic                      rst;
  logic                      psel;
  logic                      penable;
  logic                      pwrite;
  logic [ADDR_W-1:0]         paddr;
  logic [DATA_W-1:0]         pwdata;
  logic [DATA_W-1:0]         prdata;
  logic                      pready;
  logic                      point_valid;
  logic                      point_stall;
  logic signed [COORD_W-1:0] point_x;
  logic signed [COORD_W-1:0] point_y;
  logic                      path_start;
  logic                      result_valid;
  logic                      result_stall = 1'b0;
  logic signed [COORD_W-1:0] rotated_x;
  logic signed [COORD_W-1:0] rotated_y;
  logic [TIME_W-1:0]         stamp_ms;
  int                        failures;
  int                        outstanding;

  logic sender_quiet   = 1'b0;
  logic receiver_quiet = 1'b0;
  logic result_taken   = 1'b0;
  logic wait_drawn     = 1'b0;
  int   stall_left     = 0;

  time_rotating_path_transform u_top (.*);

  time_rotating_path_transform_checker u_checker (.*);

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  always @(posedge clk) begin
    result_taken <= result_valid && !result_stall;
  end

  // The receiver draws a random stall for each word before it takes it, none when receiver_quiet is set.
  always @(negedge clk) begin
    if (result_taken) begin
      wait_drawn = 1'b0;
    end
    if (result_valid === 1'b1 && !wait_drawn) begin
      stall_left = receiver_quiet ? 0 : $urandom_range(0, 3);
      wait_drawn = 1'b1;
    end
    if (stall_left > 0) begin
      result_stall <= 1'b1;
      stall_left--;
    end else begin
      result_stall <= 1'b0;
    end
  end

  function automatic logic signed [COORD_W-1:0] random_coord();
    case ($urandom_range(0, 7))
      0: return COORD_MAX;
      1: return COORD_MIN;
      2: return COORD_W'($urandom_range(0, 1023) - 512);
      default: return COORD_W'($urandom);
    endcase
  endfunction

  function automatic logic signed [SHIFT_W-1:0] random_shift();
    case ($urandom_range(0, 4))
      0: return SHIFT_MIN;
      1: return SHIFT_MAX;
      2: return '0;
      default: return SHIFT_W'($urandom);
    endcase
  endfunction

  task automatic write_reg(input logic [REG_IDX_W-1:0] idx, input logic [DATA_W-1:0] data);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= ADDR_W'({idx, 3'b000});
    pwdata  <= data;
    @(negedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    @(negedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(negedge clk);
  endtask

  task automatic read_reg(input logic [REG_IDX_W-1:0] idx);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    paddr   <= ADDR_W'({idx, 3'b000});
    @(negedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    @(negedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    @(negedge clk);
  endtask

  // Bits above the register width carry junk that the block must drop.
  task automatic write_field(input logic [REG_IDX_W-1:0] idx, input logic [63:0] value,
                             input int width);
    logic [63:0] mask;
    mask = (64'd1 << width) - 64'd1;
    write_reg(idx, ({$urandom, $urandom} << width) | (value & mask));
  endtask

  task automatic set_config(input logic [RATE_W-1:0] rate, input logic [STEP_W-1:0] step,
                            input logic [TIME_W-1:0] start,
                            input logic [SHIFT_W-1:0] sx, input logic [SHIFT_W-1:0] sy);
    write_field(REG_ANGULAR_RATE, 64'(rate), RATE_W);
    write_field(REG_TIME_STEP_MS, 64'(step), STEP_W);
    write_field(REG_START_TIME_MS, 64'(start), TIME_W);
    write_field(REG_SHIFT_X, 64'(sx), SHIFT_W);
    write_field(REG_SHIFT_Y, 64'(sy), SHIFT_W);
    for (int i = 0; i < (1 << REG_IDX_W); i++) begin
      read_reg(REG_IDX_W'(i));
    end
  endtask

  task automatic send_point(input logic signed [COORD_W-1:0] x,
                            input logic signed [COORD_W-1:0] y, input logic s);
    int gap;
    gap = sender_quiet ? 0 : $urandom_range(0, 3);
    if (gap > 0) begin
      point_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    point_x     <= x;
    point_y     <= y;
    path_start  <= s;
    point_valid <= 1'b1;
    do @(posedge clk); while (point_stall);
    @(negedge clk);
  endtask

  task automatic drain();
    point_valid <= 1'b0;
    while (outstanding != 0) @(negedge clk);
    repeat (24) @(negedge clk);
  endtask

  initial begin : stimulus
    int                        sent;
    int                        phase_len;
    int                        path_len;
    int                        n;
    int                        k;
    logic [RATE_W-1:0]         rate;
    logic [STEP_W-1:0]         step;
    logic [TIME_W-1:0]         start;
    logic signed [COORD_W-1:0] x;
    logic signed [COORD_W-1:0] y;
    logic                      s;
    rst         = 1'b1;
    psel        = 1'b0;
    penable     = 1'b0;
    pwrite      = 1'b0;
    paddr       = '0;
    pwdata      = '0;
    point_valid = 1'b0;
    point_x     = '0;
    point_y     = '0;
    path_start  = 1'b0;
    repeat (10) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // Points before any path start run on the time counter from zero.
    send_point(COORD_MAX, COORD_MIN, 1'b0);
    send_point(COORD_MIN, COORD_MAX, 1'b0);
    send_point('0, '0, 1'b0);
    drain();
    for (int i = REG_SHIFT_Y + 1; i < (1 << REG_IDX_W); i++) begin
      write_reg(REG_IDX_W'(i), '1);
    end
    set_config(32'h4000_0000, 8'd0, 48'd1, SHIFT_MAX, SHIFT_MIN);
    send_point(COORD_MAX, COORD_MAX, 1'b1);
    send_point(COORD_MIN, COORD_MIN, 1'b0);
    send_point(20'sd1, -20'sd1, 1'b0);
    drain();
    set_config(32'h8000_0000, 8'd0, 48'd1, SHIFT_MAX, SHIFT_MAX);
    send_point(COORD_MAX, '0, 1'b1);
    send_point(20'sd12345, -20'sd54321, 1'b0);
    drain();
    set_config(32'hC000_0000, 8'd0, 48'd1, '0, '0);
    send_point(COORD_MIN, COORD_MAX, 1'b1);
    drain();
    // One eighth of a turn exactly rounds up to the next quarter; just below it does not.
    set_config(32'h2000_0000, 8'd0, 48'd1, '0, '0);
    send_point(20'sh40000, 20'sh20000, 1'b1);
    drain();
    set_config(32'h1FFF_FFFF, 8'd0, 48'd1, '0, '0);
    send_point(20'sh40000, 20'sh20000, 1'b1);
    drain();
    // The time stamp wraps around the top of its range.
    set_config(32'h7FFF_FFFF, 8'd255, 48'hFFFF_FFFF_FFFE, '0, '0);
    send_point(20'sd1000, 20'sd2000, 1'b1);
    send_point(-20'sd3000, 20'sd4000, 1'b0);
    send_point(COORD_MAX, COORD_MAX, 1'b0);
    send_point(COORD_MIN, 20'sd5, 1'b0);
    drain();
    set_config(32'h0123_4567, 8'd4, '0, SHIFT_MIN, SHIFT_MAX);
    send_point(COORD_MAX, COORD_MAX, 1'b1);
    send_point(COORD_MIN, COORD_MIN, 1'b0);
    send_point('0, '0, 1'b0);

    sent = 0;
    while (sent < RANDOM_ITEMS) begin
      drain();
      case ($urandom_range(0, 4))
        0: rate = 32'h8000_0000;
        1: rate = 32'h7FFF_FFFF;
        2: rate = 32'($urandom_range(0, 4000)) - 32'd2000;
        default: rate = $urandom;
      endcase
      case ($urandom_range(0, 4))
        0: step = '0;
        1: step = '1;
        default: step = STEP_W'($urandom);
      endcase
      case ($urandom_range(0, 3))
        0: start = '0;
        1: start = 48'hFFFF_FFFF_FFFF - TIME_W'($urandom_range(0, 5000));
        default: start = TIME_W'({$urandom, $urandom});
      endcase
      set_config(rate, step, start, random_shift(), random_shift());
      sender_quiet   = ($urandom_range(0, 3) == 0);
      receiver_quiet = ($urandom_range(0, 3) == 0);
      phase_len = $urandom_range(60, 140);
      n = 0;
      while (n < phase_len) begin
        path_len = $urandom_range(1, 40);
        k = 0;
        while (k < path_len && n < phase_len) begin
          x = random_coord();
          y = random_coord();
          if ($urandom_range(0, 9) == 0) begin
            s = 1'($urandom_range(0, 1));
          end else begin
            s = (k == 0);
          end
          send_point(x, y, s);
          k++;
          n++;
        end
      end
      sent += phase_len;
    end
    sender_quiet   = 1'b0;
    receiver_quiet = 1'b0;
    drain();
    if (failures == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

  initial begin
    #5_000_000;
    $display("CHECKS FAILED");
    $finish;
  end

endmodule
